FILE: design/yaz0_pkg.sv
// ============================================================================
// yaz0_pkg
// Shared types and constants of the Yaz0 stream decompressor.
// ============================================================================
package yaz0_pkg;

    // Format constants
    localparam int WINDOW_SIZE_DEF      = 4096;
    localparam int BYTES_PER_RESULT_DEF = 8;
    localparam int DATA_BYTES           = 8;
    localparam int COUNT_W              = 4;
    localparam int HEADER_BYTES         = 16;
    localparam int SIZE_FIRST_POS       = 4;
    localparam int SIZE_LAST_POS        = 7;
    localparam int SHORT_LEN_BASE       = 2;
    localparam int LONG_LEN_BASE        = 18;
    localparam int DIST_W               = 12;
    localparam int FLAGS_PER_BYTE       = 8;

    // One compressed input byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } t_in_item;

    // One packed group of expanded bytes
    typedef struct packed {
        logic [8*DATA_BYTES-1:0] data;
        logic [COUNT_W-1:0]      byte_count;
        logic                    last_of_run;
        logic                    end_of_output;
        logic                    truncated;
    } t_out_item;

    // Commands from the sequencer to the packer
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       emit;
        logic       last;
        logic       end_flag;
        logic       trunc;
    } t_pack_ctrl;

    // Stream parse phase
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FLAG,
        PH_ITEM,
        PH_REF_LO,
        PH_REF_EXTRA,
        PH_DONE
    } t_phase;

    // Sequencer state
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_READ,
        SQ_WRITE,
        SQ_SPILL,
        SQ_FLUSH
    } t_seq_state;

endpackage

FILE: design/yaz0_ram.sv
// ============================================================================
// yaz0_ram
// Generic single-clock RAM with one write port and one registered read port.
// ============================================================================
module yaz0_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/yaz0_packer.sv
// ============================================================================
// yaz0_packer
// Gathers expanded bytes into result words and holds the output register.
// ============================================================================
module yaz0_packer #(
    parameter int BYTES_PER_RESULT = yaz0_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  yaz0_pkg::t_pack_ctrl i_ctrl,
    output logic                 o_full,
    output logic                 o_slot_free,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output yaz0_pkg::t_out_item  o_out_item
);
    import yaz0_pkg::*;

    logic [8*DATA_BYTES-1:0] r_data, n_data;
    logic [COUNT_W-1:0]      r_n, n_n;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;

    assign o_full      = (r_n == COUNT_W'(BYTES_PER_RESULT));
    assign o_slot_free = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Lane insert, emit and output register handling
    always_comb begin
        n_data      = r_data;
        n_n         = r_n;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (i_ctrl.push) begin
            for (int i = 0; i < DATA_BYTES; i++) begin
                if (r_n == COUNT_W'(i)) begin
                    n_data[8*i +: 8] = i_ctrl.push_byte;
                end
            end
            n_n = r_n + COUNT_W'(1);
        end
        if (i_ctrl.emit) begin
            n_out.data          = r_data;
            n_out.byte_count    = r_n;
            n_out.last_of_run   = i_ctrl.last;
            n_out.end_of_output = i_ctrl.end_flag;
            n_out.truncated     = i_ctrl.trunc;
            n_out_valid         = 1'b1;
            n_data              = '0;
            n_n                 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data      <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_data      <= n_data;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

FILE: design/yaz0_decompressor.sv
// ============================================================================
// yaz0_decompressor
// Yaz0 stream decompressor with a history ring and packed byte output.
// ============================================================================
// The block takes one compressed byte per input transfer, header included,
// and delivers the expanded bytes packed up to BYTES_PER_RESULT per output
// transfer. Header, flag and reference bytes that produce nothing are
// taken without stalling the input. A literal is accepted, then handed to
// the output register from the flush state. A back-reference is paced by
// the single history RAM: each copied byte is read in the read state and
// written back in the write state that follows. The input is stalled for
// the whole copy; a full, stalled output register holds back any run. The
// history ring is not cleared after reset or a new file; a read behind the
// first byte of the current file is returned as zero by comparing against
// the produced count.
// ============================================================================
module yaz0_decompressor #(
    parameter int WINDOW_SIZE      = yaz0_pkg::WINDOW_SIZE_DEF,
    parameter int BYTES_PER_RESULT = yaz0_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  yaz0_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output yaz0_pkg::t_out_item o_out_item
);
    import yaz0_pkg::*;

    localparam int AW = $clog2(WINDOW_SIZE);

    // Parser and sequencer state
    t_seq_state  r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [4:0]  r_hdr_pos, n_hdr_pos;
    logic [31:0] r_size, n_size;
    logic [31:0] r_pc, n_pc;
    logic [7:0]  r_flags, n_flags;
    logic [3:0]  r_flags_left, n_flags_left;
    logic [15:0] r_ref, n_ref;
    logic [8:0]  r_left, n_left;
    logic        r_cut, n_cut;

    // State as seen by an accepted byte; a first byte sees the reset state
    t_phase      e_phase;
    logic [4:0]  e_hdr_pos;
    logic [31:0] e_size;
    logic [31:0] e_pc;
    logic [7:0]  e_flags;
    logic [3:0]  e_flags_left;
    logic [15:0] e_ref;

    logic        accept;
    logic [7:0]  in_byte;
    logic [31:0] copy_dist;
    logic [31:0] src_pos;
    logic        src_valid;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    t_pack_ctrl pack_ctrl;
    logic       pack_full;
    logic       slot_free;

    assign o_in_stall = (r_state != SQ_IDLE);
    assign accept     = i_in_valid && (r_state == SQ_IDLE);
    assign in_byte    = i_in.data_byte;

    assign e_phase      = i_in.first ? PH_HEADER : r_phase;
    assign e_hdr_pos    = i_in.first ? '0 : r_hdr_pos;
    assign e_size       = i_in.first ? '0 : r_size;
    assign e_pc         = i_in.first ? '0 : r_pc;
    assign e_flags      = i_in.first ? '0 : r_flags;
    assign e_flags_left = i_in.first ? '0 : r_flags_left;
    assign e_ref        = i_in.first ? '0 : r_ref;

    // Copy source: one subtract and one compare against the produced count
    assign copy_dist = 32'(r_ref[DIST_W-1:0]) + 32'd1;
    assign src_pos   = r_pc - copy_dist;
    assign src_valid = (r_pc >= copy_dist);

    // Parser and copy sequencer
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_hdr_pos    = r_hdr_pos;
        n_size       = r_size;
        n_pc         = r_pc;
        n_flags      = r_flags;
        n_flags_left = r_flags_left;
        n_ref        = r_ref;
        n_left       = r_left;
        n_cut        = r_cut;
        ram_we       = 1'b0;
        ram_waddr    = r_pc[AW-1:0];
        ram_wdata    = in_byte;
        ram_re       = 1'b0;
        ram_raddr    = src_pos[AW-1:0];
        pack_ctrl    = '0;

        unique case (r_state)
            SQ_IDLE: begin
                if (accept) begin
                    n_phase      = e_phase;
                    n_hdr_pos    = e_hdr_pos;
                    n_size       = e_size;
                    n_pc         = e_pc;
                    n_flags      = e_flags;
                    n_flags_left = e_flags_left;
                    n_ref        = e_ref;
                    unique case (e_phase)
                        PH_HEADER: begin
                            if (e_hdr_pos >= 5'(SIZE_FIRST_POS) &&
                                e_hdr_pos <= 5'(SIZE_LAST_POS)) begin
                                n_size = {e_size[23:0], in_byte};
                            end
                            n_hdr_pos = e_hdr_pos + 5'd1;
                            if (n_hdr_pos >= 5'(HEADER_BYTES)) begin
                                if (n_size == '0 || n_size[31]) begin
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = PH_FLAG;
                                end
                            end
                        end
                        PH_FLAG: begin
                            n_flags      = in_byte;
                            n_flags_left = 4'(FLAGS_PER_BYTE);
                            n_phase      = PH_ITEM;
                        end
                        PH_ITEM: begin
                            if (e_flags[7]) begin
                                // Literal byte: store, pack, then flush
                                ram_we              = 1'b1;
                                ram_waddr           = e_pc[AW-1:0];
                                pack_ctrl.push      = 1'b1;
                                pack_ctrl.push_byte = in_byte;
                                n_pc                = e_pc + 32'd1;
                                n_cut               = 1'b0;
                                n_state             = SQ_FLUSH;
                            end else begin
                                n_ref   = {in_byte, 8'h00};
                                n_phase = PH_REF_LO;
                            end
                        end
                        PH_REF_LO: begin
                            n_ref = {e_ref[15:8], in_byte};
                            if (n_ref[15:12] != 4'd0) begin
                                n_left  = 9'(n_ref[15:12]) + 9'(SHORT_LEN_BASE);
                                n_cut   = 1'b0;
                                n_state = SQ_READ;
                            end else begin
                                n_phase = PH_REF_EXTRA;
                            end
                        end
                        PH_REF_EXTRA: begin
                            n_left  = 9'(in_byte) + 9'(LONG_LEN_BASE);
                            n_cut   = 1'b0;
                            n_state = SQ_READ;
                        end
                        PH_DONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            SQ_READ: begin
                // Stop at the copy length or at the expanded size
                if (r_left == '0 || r_pc >= r_size) begin
                    n_cut   = (r_left != '0);
                    n_state = SQ_FLUSH;
                end else if (pack_full) begin
                    n_state = SQ_SPILL;
                end else begin
                    ram_re  = 1'b1;
                    n_state = SQ_WRITE;
                end
            end
            SQ_WRITE: begin
                // Bytes behind the start of the file read as zero
                ram_we              = 1'b1;
                ram_wdata           = src_valid ? ram_rdata : 8'h00;
                pack_ctrl.push      = 1'b1;
                pack_ctrl.push_byte = ram_wdata;
                n_pc                = r_pc + 32'd1;
                n_left              = r_left - 9'd1;
                n_state             = SQ_READ;
            end
            SQ_SPILL: begin
                if (slot_free) begin
                    pack_ctrl.emit     = 1'b1;
                    pack_ctrl.end_flag = (r_pc == r_size);
                    n_state            = SQ_READ;
                end
            end
            SQ_FLUSH: begin
                if (slot_free) begin
                    pack_ctrl.emit     = 1'b1;
                    pack_ctrl.last     = 1'b1;
                    pack_ctrl.end_flag = (r_pc == r_size);
                    pack_ctrl.trunc    = r_cut;
                    // Advance to the next flag bit
                    n_flags = {r_flags[6:0], 1'b0};
                    if (r_flags_left != 4'd0) begin
                        n_flags_left = r_flags_left - 4'd1;
                    end
                    if (r_pc >= r_size) begin
                        n_phase = PH_DONE;
                    end else if (n_flags_left == 4'd0) begin
                        n_phase = PH_FLAG;
                    end else begin
                        n_phase = PH_ITEM;
                    end
                    n_state = SQ_IDLE;
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= SQ_IDLE;
            r_phase      <= PH_HEADER;
            r_hdr_pos    <= '0;
            r_size       <= '0;
            r_pc         <= '0;
            r_flags      <= '0;
            r_flags_left <= '0;
            r_ref        <= '0;
            r_left       <= '0;
            r_cut        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_hdr_pos    <= n_hdr_pos;
            r_size       <= n_size;
            r_pc         <= n_pc;
            r_flags      <= n_flags;
            r_flags_left <= n_flags_left;
            r_ref        <= n_ref;
            r_left       <= n_left;
            r_cut        <= n_cut;
        end
    end

    // History ring
    yaz0_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result packing and output register
    yaz0_packer #(
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (pack_ctrl),
        .o_full      (pack_full),
        .o_slot_free (slot_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: test/tb_yaz0_decompressor.sv
// ============================================================================
// tb_yaz0_decompressor
// Self-checking testbench for the Yaz0 stream decompressor.
// ============================================================================
// Compressed files are built as byte streams and sent through the input
// channel, one byte per transfer. A behavioral decoder in this file follows
// every accepted byte and queues the packed output groups it should cause.
// The monitor compares each output transfer field by field with the oldest
// queued group. The stream opens with a hand-built file that covers the
// longest copy, a reference behind the start of the file and a copy cut at
// the expanded size. Random files follow, most of them well formed, some cut
// short by a new file, some with an oversized or zero expanded size, and
// some made of random bytes. Both channels idle and stall at random.
// ============================================================================
module tb_yaz0_decompressor;

    import yaz0_pkg::*;

    localparam int RING_SIZE    = WINDOW_SIZE_DEF;
    localparam int GROUP_BYTES  = BYTES_PER_RESULT_DEF;
    localparam int TARGET_ITEMS = 270;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 50;

    // Kinds of generated files
    typedef enum int {
        FILE_NORMAL,
        FILE_NOISE,
        FILE_HUGE_SIZE,
        FILE_EMPTY
    } t_file_kind;

    // One pending input transfer and the idle cycles that go before it
    typedef struct {
        t_in_item    item;
        int unsigned gap;
    } t_pending;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // Stimulus and checking bookkeeping
    t_pending    pending[$];
    t_pending    next_entry;
    bit          have_next;
    int unsigned wait_cnt;
    int unsigned items_taken;
    int unsigned items_total;
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned idle_cycles;
    int unsigned err_count;
    bit          quiet_file;
    logic [7:0]  opening [25];

    // Decoder state followed by the testbench
    logic [4:0]  hdr_pos;
    logic [31:0] out_size;
    logic [31:0] out_count;
    logic [7:0]  flag_reg;
    logic [3:0]  flag_cnt;
    t_phase      phase;
    logic [15:0] ref_word;
    logic [7:0]  ring [RING_SIZE];
    logic [63:0] grp_data;
    int unsigned grp_n;
    t_out_item   step_groups[$];
    t_out_item   exp_groups[$];

    yaz0_decompressor i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Decoder
    // ------------------------------------------------------------------------

    // Clears the whole decoder state, the history ring included.
    function automatic void clear_decoder();
        hdr_pos   = '0;
        out_size  = '0;
        out_count = '0;
        flag_reg  = '0;
        flag_cnt  = '0;
        phase     = PH_HEADER;
        ref_word  = '0;
        for (int i = 0; i < RING_SIZE; i++) begin
            ring[i] = 8'h00;
        end
    endfunction

    // Closes the group being packed, if it holds any byte.
    function automatic void close_group();
        t_out_item g;
        if (grp_n == 0) begin
            return;
        end
        g.data          = grp_data;
        g.byte_count    = 4'(grp_n);
        g.last_of_run   = 1'b0;
        g.end_of_output = (out_count == out_size);
        g.truncated     = 1'b0;
        step_groups.push_back(g);
        grp_data = '0;
        grp_n    = 0;
    endfunction

    // Writes one expanded byte to the ring and to the group being packed.
    function automatic void put_byte(logic [7:0] b);
        ring[out_count[11:0]] = b;
        out_count++;
        grp_data |= 64'(b) << (8 * grp_n);
        grp_n++;
        if (grp_n >= GROUP_BYTES || out_count == out_size) begin
            close_group();
        end
    endfunction

    // Moves to the next flag bit, or to the end once the size is reached.
    function automatic void finish_item();
        flag_reg = flag_reg << 1;
        if (flag_cnt > 0) begin
            flag_cnt--;
        end
        if (out_count >= out_size) begin
            phase = PH_DONE;
        end else if (flag_cnt == 0) begin
            phase = PH_FLAG;
        end else begin
            phase = PH_ITEM;
        end
    endfunction

    // Copies bytes from the ring; returns 1 when the size cuts the copy.
    function automatic bit copy_back(int unsigned count);
        int unsigned copy_dist;
        logic [31:0] src;
        copy_dist = int'(ref_word[11:0]) + 1;
        for (int unsigned i = 0; i < count; i++) begin
            if (out_count >= out_size) begin
                return 1'b1;
            end
            src = out_count - copy_dist;
            put_byte(ring[src[11:0]]);
        end
        return 1'b0;
    endfunction

    // Follows one accepted input byte and queues the groups it causes.
    function automatic void decode_byte(t_in_item it);
        logic [7:0] b;
        bit         cut;
        t_out_item  tail;
        b   = it.data_byte;
        cut = 1'b0;
        if (it.first) begin
            clear_decoder();
        end
        step_groups.delete();
        grp_data = '0;
        grp_n    = 0;
        case (phase)
            PH_HEADER: begin
                if (hdr_pos >= SIZE_FIRST_POS && hdr_pos <= SIZE_LAST_POS) begin
                    out_size = {out_size[23:0], b};
                end
                hdr_pos++;
                if (hdr_pos >= HEADER_BYTES) begin
                    phase = (out_size == 0 || out_size[31]) ? PH_DONE : PH_FLAG;
                end
            end
            PH_FLAG: begin
                flag_reg = b;
                flag_cnt = 4'(FLAGS_PER_BYTE);
                phase    = PH_ITEM;
            end
            PH_ITEM: begin
                if (flag_reg[7]) begin
                    put_byte(b);
                    finish_item();
                end else begin
                    ref_word = {b, 8'h00};
                    phase    = PH_REF_LO;
                end
            end
            PH_REF_LO: begin
                ref_word[7:0] = b;
                if (ref_word[15:12] != 0) begin
                    cut = copy_back(int'(ref_word[15:12]) + SHORT_LEN_BASE);
                    finish_item();
                end else begin
                    phase = PH_REF_EXTRA;
                end
            end
            PH_REF_EXTRA: begin
                cut = copy_back(int'(b) + LONG_LEN_BASE);
                finish_item();
            end
            default: begin
            end
        endcase
        close_group();
        // The final group of this byte carries the run end and the cut flag.
        if (step_groups.size() > 0) begin
            tail = step_groups[step_groups.size() - 1];
            tail.last_of_run = 1'b1;
            tail.truncated   = cut;
            step_groups[step_groups.size() - 1] = tail;
        end
        foreach (step_groups[k]) begin
            exp_groups.push_back(step_groups[k]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------

    // Idle length: mostly none, sometimes short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    function automatic void queue_byte(logic [7:0] b, logic f);
        t_pending p;
        p.item.data_byte = b;
        p.item.first     = f;
        p.gap            = quiet_file ? 0 : pick_gap();
        pending.push_back(p);
    endfunction

    // Header with random filler around the big-endian expanded size.
    function automatic void add_header(logic [31:0] size);
        logic [7:0] b;
        for (int i = 0; i < HEADER_BYTES; i++) begin
            if (i >= SIZE_FIRST_POS && i <= SIZE_LAST_POS) begin
                b = size[8 * (SIZE_LAST_POS - i) +: 8];
            end else begin
                b = 8'($urandom);
            end
            queue_byte(b, i == 0);
        end
    endfunction

    // A few bytes past the end of a file; the block ignores them.
    function automatic void add_trailing();
        repeat ($urandom_range(0, 3)) begin
            queue_byte(8'($urandom), 1'b0);
        end
    endfunction

    function automatic void add_file(t_file_kind kind);
        logic [31:0] size;
        int unsigned made;
        int unsigned len;
        int unsigned copy_dist;
        int unsigned stop_at;
        int unsigned r;
        logic [7:0]  flags;
        logic [3:0]  nib;
        logic [7:0]  extra;
        logic [15:0] word;
        case (kind)
            FILE_HUGE_SIZE: begin
                add_header({1'b1, 31'($urandom)});
                add_trailing();
                return;
            end
            FILE_EMPTY: begin
                add_header(32'h0);
                add_trailing();
                return;
            end
            FILE_NOISE: begin
                queue_byte(8'($urandom), 1'b1);
                repeat ($urandom_range(15, 35)) begin
                    queue_byte(8'($urandom), 1'b0);
                end
                return;
            end
            default: begin
            end
        endcase

        // Well-formed file, now and then broken off by the next file.
        r = $urandom_range(0, 99);
        if (r < 70) begin
            size = $urandom_range(1, 24);
        end else if (r < 95) begin
            size = $urandom_range(25, 100);
        end else begin
            size = $urandom_range(101, 400);
        end
        stop_at = ($urandom_range(0, 9) == 0) ? pending.size() + $urandom_range(17, 40) : 0;
        add_header(size);
        made = 0;
        while (made < size) begin
            flags = 8'($urandom);
            queue_byte(flags, 1'b0);
            for (int k = 7; k >= 0 && made < size; k--) begin
                if (flags[k]) begin
                    queue_byte(8'($urandom), 1'b0);
                    made++;
                end else begin
                    // Mostly near references, sometimes anywhere in the ring.
                    copy_dist = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 16)
                                                             : $urandom_range(1, RING_SIZE);
                    if ($urandom_range(0, 99) < 85) begin
                        nib = 4'($urandom_range(1, 15));
                        len = nib + SHORT_LEN_BASE;
                    end else begin
                        nib   = 4'h0;
                        extra = ($urandom_range(0, 99) < 90) ? 8'($urandom_range(0, 24))
                                                             : 8'($urandom);
                        len   = extra + LONG_LEN_BASE;
                    end
                    word = {nib, 12'(copy_dist - 1)};
                    queue_byte(word[15:8], 1'b0);
                    queue_byte(word[7:0], 1'b0);
                    if (nib == 0) begin
                        queue_byte(extra, 1'b0);
                    end
                    made += len;
                end
                if (stop_at != 0 && pending.size() >= stop_at) begin
                    return;
                end
            end
        end
        add_trailing();
    endfunction

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            have_next = 1'b0;
            wait_cnt  = 0;
        end else begin
            if (in_valid && !in_stall) begin
                decode_byte(in_item);
                items_taken++;
            end
            // A new byte may be offered once the current one is taken.
            if (!in_valid || !in_stall) begin
                if (!have_next && pending.size() > 0) begin
                    next_entry = pending.pop_front();
                    wait_cnt   = next_entry.gap;
                    have_next  = 1'b1;
                end
                if (have_next && wait_cnt == 0) begin
                    in_item   <= next_entry.item;
                    in_valid  <= 1'b1;
                    have_next = 1'b0;
                end else begin
                    if (have_next) begin
                        wait_cnt--;
                    end
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor
    // ------------------------------------------------------------------------
    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_group(t_out_item got);
        t_out_item want;
        if (exp_groups.size() == 0) begin
            report_error($sformatf("output transfer with nothing expected, data %h",
                                   got.data));
            return;
        end
        want = exp_groups.pop_front();
        if (got.data !== want.data) begin
            report_error($sformatf("data: expected %h, got %h", want.data, got.data));
        end
        if (got.byte_count !== want.byte_count) begin
            report_error($sformatf("byte_count: expected %0d, got %0d",
                                   want.byte_count, got.byte_count));
        end
        if (got.last_of_run !== want.last_of_run) begin
            report_error($sformatf("last_of_run: expected %b, got %b",
                                   want.last_of_run, got.last_of_run));
        end
        if (got.end_of_output !== want.end_of_output) begin
            report_error($sformatf("end_of_output: expected %b, got %b",
                                   want.end_of_output, got.end_of_output));
        end
        if (got.truncated !== want.truncated) begin
            report_error($sformatf("truncated: expected %b, got %b",
                                   want.truncated, got.truncated));
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
            calm_left  = 0;
        end else begin
            if (out_valid && !out_stall) begin
                check_group(out_item);
            end
            // Stalls of random length, with stretches of no stall at all.
            if (calm_left > 0) begin
                calm_left--;
                out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                if ($urandom_range(0, 99) < 4) begin
                    calm_left = $urandom_range(40, 200);
                end else begin
                    stall_left = pick_gap();
                end
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles without any transfer on either channel
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Timeout after %0d cycles without a transfer", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_file_kind  kind;
        int unsigned file_no;
        int unsigned r;

        clear_decoder();

        // Opening file, sent without a first marker right after reset.
        // Expanded size 288. A long reference of the longest length reaches
        // the full window back behind the start of the file, then two literal
        // bytes, then a short copy of the longest length that the size cuts.
        // The last byte comes after the end and is ignored.
        quiet_file = 1'b0;
        opening = '{8'h59, 8'h61, 8'h7A, 8'h30, 8'h00, 8'h00, 8'h01, 8'h20,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h6F, 8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hF0, 8'h00,
                    8'hAA};
        foreach (opening[k]) begin
            queue_byte(opening[k], 1'b0);
        end

        // Random files; the first two have an oversized and a zero size.
        file_no = 0;
        while (pending.size() < TARGET_ITEMS) begin
            quiet_file = (file_no % 3 == 2);
            r = $urandom_range(0, 99);
            if (file_no == 0) begin
                kind = FILE_HUGE_SIZE;
            end else if (file_no == 1) begin
                kind = FILE_EMPTY;
            end else if (r < 80) begin
                kind = FILE_NORMAL;
            end else if (r < 90) begin
                kind = FILE_NOISE;
            end else if (r < 95) begin
                kind = FILE_HUGE_SIZE;
            end else begin
                kind = FILE_EMPTY;
            end
            add_file(kind);
            file_no++;
        end
        items_total = pending.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every byte is taken and every group has arrived.
        while (!(items_taken == items_total && exp_groups.size() == 0)) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
